[rtl/sru_pkg.sv]
// ----------------------------------------------------------------------------
// sru_pkg
// shared types and constants of the scaler record unwrap and rate block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sru_pkg;

	localparam int DEF_MAX_CHANNELS  = 64;
	localparam int DEF_WRAP_BITS     = 24;
	localparam int DEF_EXTENDED_BITS = 48;

	localparam logic [31:0] SCALER_TYPE        = 32'd21;
	localparam int          COUNT_WORD         = 8;
	localparam int          FIRST_COUNTER_WORD = 9;
	localparam logic [31:0] TPS_RESET          = 32'd100000000;

	localparam int          RATE_W   = 40;
	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	typedef struct packed {
		logic [31:0] word;
		logic        record_start;
		logic [63:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [5:0]        channel;
		logic [47:0]       extended_count;
		logic [RATE_W-1:0] rate;
		logic              rate_valid;
		logic              last_of_record;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] delta;
		logic [31:0] tps;
		logic [63:0] dt;
	} rate_req_t;

	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] rate;
	} rate_rsp_t;

endpackage

`default_nettype wire

[rtl/sru_ram.sv]
// ----------------------------------------------------------------------------
// sru_ram
// generic single-port-write, registered-read ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sru_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/sru_rate_div.sv]
// ----------------------------------------------------------------------------
// sru_rate_div
// rate = floor(delta * tps / dt), saturating; one 32x32 multiplier used twice,
// then a restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sru_rate_div
	import sru_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire rate_req_t req,
	output rate_rsp_t      rsp
);

	typedef enum logic [6:0] {
		R_IDLE   = 7'b0000001,
		R_MUL_LO = 7'b0000010,
		R_MUL_HI = 7'b0000100,
		R_SUM    = 7'b0001000,
		R_CHECK  = 7'b0010000,
		R_DIV    = 7'b0100000,
		R_FIN    = 7'b1000000
	} rstate_t;

	rstate_t     state_q;
	logic [63:0] delta_q;
	logic [31:0] tps_q;
	logic [63:0] dt_q;
	logic [63:0] p_lo_q;
	logic [63:0] p_hi_q;
	logic [63:0] lo_q;
	logic [63:0] hi_q;
	logic [63:0] r_q;
	logic [63:0] quo_q;
	logic [5:0]  cnt_q;
	logic        sat_q;

	logic [31:0] mul_a;
	logic [63:0] prod;
	logic [64:0] lo_sum;
	logic [64:0] rem_sh;
	logic [64:0] rem_sub;
	logic        take;

	assign mul_a  = (state_q == R_MUL_HI) ? delta_q[63:32] : delta_q[31:0];
	assign prod   = mul_a * tps_q;
	assign lo_sum = {1'b0, p_lo_q} + {1'b0, p_hi_q[31:0], 32'b0};

	// remainder shifted with the next dividend bit; its top bit forces a subtract
	assign rem_sh  = {r_q, lo_q[63]};
	assign rem_sub = rem_sh - {1'b0, dt_q};
	assign take    = (rem_sh >= {1'b0, dt_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
		end else begin
			case (state_q)
				R_IDLE:   if (req.start) state_q <= R_MUL_LO;
				R_MUL_LO: state_q <= R_MUL_HI;
				R_MUL_HI: state_q <= R_SUM;
				R_SUM:    state_q <= R_CHECK;
				R_CHECK:  state_q <= (hi_q >= dt_q) ? R_FIN : R_DIV;
				R_DIV:    if (cnt_q == '0) state_q <= R_FIN;
				R_FIN:    state_q <= R_IDLE;
				default:  state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				delta_q <= req.delta;
				tps_q   <= req.tps;
				dt_q    <= req.dt;
			end
			R_MUL_LO: p_lo_q <= prod;
			R_MUL_HI: p_hi_q <= prod;
			R_SUM: begin
				lo_q <= lo_sum[63:0];
				hi_q <= {32'b0, p_hi_q[63:32]} + {63'b0, lo_sum[64]};
			end
			R_CHECK: begin
				sat_q <= (hi_q >= dt_q);
				r_q   <= hi_q;
				quo_q <= '0;
				cnt_q <= '1;
			end
			R_DIV: begin
				r_q   <= take ? rem_sub[63:0] : rem_sh[63:0];
				lo_q  <= {lo_q[62:0], 1'b0};
				quo_q <= {quo_q[62:0], take};
				cnt_q <= cnt_q - 6'd1;
			end
			default: ;
		endcase
	end

	assign rsp.done = (state_q == R_FIN);
	assign rsp.rate = (sat_q || (|quo_q[63:RATE_W])) ? RATE_MAX : quo_q[RATE_W-1:0];

endmodule

`default_nettype wire

[rtl/scaler_record_unwrap_rate_top.sv]
// ----------------------------------------------------------------------------
// scaler_record_unwrap_rate_top
// scaler record parser, counter overflow extension and per-channel rate
// ----------------------------------------------------------------------------
// Words that produce no result (header words, words of skipped records, words
// past the channel count) are taken at one word per cycle while the block is
// idle. A counter word of a channel with no history goes straight to the done
// state. A counter word of a channel with history passes through a read of the
// history ram, the compare and ceiling steps of the widening, one more step
// when it wraps, the delta, two passes through the one 32x32 multiplier, a
// sum, a range check and a 64-step restoring divider that gives one quotient
// bit per cycle. A rate that saturates at the range check skips the divider.
// When the count did not move it skips the rate steps. A finished result
// waits in the done state until the output register is free, and the block
// takes no new word until the register is free for the next one.
`timescale 1ns / 1ps
`default_nettype none

module scaler_record_unwrap_rate_top
	import sru_pkg::*;
#(
	parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
	parameter int WRAP_BITS     = DEF_WRAP_BITS,
	parameter int EXTENDED_BITS = DEF_EXTENDED_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        cfg_wen,
	input  wire logic [31:0] cfg_wdata
);

	localparam int EXT     = EXTENDED_BITS;
	localparam int W       = WRAP_BITS;
	localparam int KW      = EXT - W + 1;
	localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
	localparam int POS_MAX = FIRST_COUNTER_WORD + MAX_CHANNELS;
	localparam int POS_W   = $clog2(POS_MAX + 1);
	localparam logic [EXT-1:0] EXT_MAX = '1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_READ  = 8'b00000010,
		S_CMP   = 8'b00000100,
		S_CEIL  = 8'b00001000,
		S_WIDEN = 8'b00010000,
		S_DELTA = 8'b00100000,
		S_RATE  = 8'b01000000,
		S_DONE  = 8'b10000000
	} state_t;

	state_t             state_q;
	logic [31:0]        tps_q;
	logic [POS_W-1:0]   pos_q;
	logic               accepted_q;
	logic [CNT_W-1:0]   kept_q;
	logic [CNT_W-1:0]   hist_cnt_q;
	logic [CNT_W-1:0]   rec_cnt_q;
	logic [63:0]        pend_ts_q;
	logic [63:0]        cur_ts_q;
	logic [63:0]        dt_q;
	logic               out_valid_q;

	logic [31:0]        raw_q;
	logic [CH_W-1:0]    ch_q;
	logic               hist_ok_q;
	logic               last_q;
	logic [EXT-1:0]     prev_q;
	logic [EXT-1:0]     diff_q;
	logic               lt_q;
	logic [KW-1:0]      k_q;
	logic [EXT-1:0]     ext_q;
	logic [RATE_W-1:0]  rate_q;
	out_item_t          out_q;

	logic               accept;
	logic [POS_W-1:0]   pos_cur;
	logic [POS_W-1:0]   ch_full;
	logic [POS_W-1:0]   ch_next;
	logic               is_counter;
	logic               start_ch;
	logic               ch_hist;
	logic [CNT_W-1:0]   kept_new;
	logic               out_free;
	logic               load_out;
	logic [EXT-1:0]     raw_ext;
	logic [EXT-1:0]     prev_rd;
	logic [EXT-W-1:0]   headroom;
	logic [KW-1:0]      k_ceil;
	logic [EXT:0]       wsum;
	logic [EXT-1:0]     delta;
	logic [EXT+63:0]    delta_pad;
	logic [EXT+47:0]    ext_pad;
	logic [CH_W+5:0]    ch_pad;
	rate_req_t          req;
	rate_rsp_t          rsp;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == S_DONE) && out_free;

	// word position within the record, a record start counts as word 0
	assign pos_cur    = in_data.record_start ? '0 : pos_q;
	assign ch_full    = pos_cur - POS_W'(FIRST_COUNTER_WORD);
	assign ch_next    = ch_full + POS_W'(1);
	assign is_counter = (pos_cur >= POS_W'(FIRST_COUNTER_WORD));
	assign start_ch   = accept && accepted_q && !in_data.record_start && is_counter
		&& (ch_full < POS_W'(kept_q));
	assign ch_hist    = (ch_full < POS_W'(rec_cnt_q));
	assign kept_new   = (in_data.word < 32'(MAX_CHANNELS)) ? in_data.word[CNT_W-1:0]
		: CNT_W'(MAX_CHANNELS);

	// widening arithmetic
	assign raw_ext  = {{(EXT-32){1'b0}}, raw_q};
	assign headroom = ~raw_ext[EXT-1:W];
	assign k_ceil   = {1'b0, diff_q[EXT-1:W]} + KW'(|diff_q[W-1:0]);
	assign wsum     = {1'b0, raw_ext} + {k_q, {W{1'b0}}};
	assign delta    = ext_q - prev_q;

	assign delta_pad = {64'b0, delta};
	assign req.start = (state_q == S_DELTA) && (ext_q != prev_q);
	assign req.delta = delta_pad[63:0];
	assign req.tps   = tps_q;
	assign req.dt    = dt_q;

	sru_rate_div u_rate (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	sru_ram #(
		.WIDTH(EXT),
		.DEPTH(MAX_CHANNELS)
	) u_hist (
		.clk  (clk),
		.we   (load_out),
		.waddr(ch_q),
		.wdata(ext_q),
		.re   (start_ch),
		.raddr(ch_full[CH_W-1:0]),
		.rdata(prev_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tps_q       <= TPS_RESET;
			pos_q       <= '0;
			accepted_q  <= 1'b0;
			kept_q      <= '0;
			hist_cnt_q  <= '0;
			rec_cnt_q   <= '0;
			pend_ts_q   <= '0;
			cur_ts_q    <= '0;
			dt_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				tps_q <= cfg_wdata;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				pos_q <= (pos_cur == POS_W'(POS_MAX)) ? pos_cur : pos_cur + POS_W'(1);
				if (in_data.record_start) begin
					pend_ts_q  <= in_data.timestamp;
					accepted_q <= 1'b0;
				end else if (pos_cur == POS_W'(1)) begin
					if (in_data.word == SCALER_TYPE) begin
						cur_ts_q <= pend_ts_q;
						// a repeated timestamp skips the record and keeps the history
						if (pend_ts_q != cur_ts_q) begin
							accepted_q <= 1'b1;
							dt_q       <= pend_ts_q - cur_ts_q;
							rec_cnt_q  <= hist_cnt_q;
							hist_cnt_q <= '0;
							kept_q     <= '0;
						end
					end
				end else if (accepted_q && pos_cur == POS_W'(COUNT_WORD)) begin
					kept_q <= kept_new;
				end
			end

			if (start_ch) begin
				hist_cnt_q <= ch_next[CNT_W-1:0];
			end

			case (state_q)
				S_IDLE:  if (start_ch) state_q <= ch_hist ? S_READ : S_DONE;
				S_READ:  state_q <= S_CMP;
				S_CMP:   state_q <= S_CEIL;
				S_CEIL:  state_q <= lt_q ? S_WIDEN : S_DELTA;
				S_WIDEN: state_q <= S_DELTA;
				S_DELTA: state_q <= (ext_q != prev_q) ? S_RATE : S_DONE;
				S_RATE:  if (rsp.done) state_q <= S_DONE;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ext_pad = {48'b0, ext_q};
	assign ch_pad  = {6'b0, ch_q};

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start_ch) begin
					raw_q     <= in_data.word;
					ch_q      <= ch_full[CH_W-1:0];
					hist_ok_q <= ch_hist;
					last_q    <= (ch_next == POS_W'(kept_q));
					ext_q     <= {{(EXT-32){1'b0}}, in_data.word};
					rate_q    <= '0;
				end
			end
			S_READ: prev_q <= prev_rd;
			S_CMP: begin
				diff_q <= prev_q - raw_ext;
				lt_q   <= (raw_ext < prev_q);
			end
			S_CEIL: begin
				ext_q <= raw_ext;
				k_q   <= k_ceil;
			end
			S_WIDEN: ext_q <= (k_q > {1'b0, headroom}) ? EXT_MAX : wsum[EXT-1:0];
			S_RATE: if (rsp.done) rate_q <= rsp.rate;
			S_DONE: begin
				if (out_free) begin
					out_q.channel        <= ch_pad[5:0];
					out_q.extended_count <= ext_pad[47:0];
					out_q.rate           <= rate_q;
					out_q.rate_valid     <= hist_ok_q;
					out_q.last_of_record <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

[rtl/sru_checker.sv]
// ----------------------------------------------------------------------------
// sru_checker
// port-level checks of the scaler record unwrap and rate block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sru_checker
	import sru_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire in_item_t    in_data,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire out_item_t   out_data
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// no history means no rate
	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rate_valid |-> out_data.rate == '0)
		else $error("rate set without channel history");

	// a record start word never yields a result
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.record_start |=> !$rose(out_valid))
		else $error("result after a record start word");

	// a new result only comes out of a busy period
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input side idle");

endmodule

bind scaler_record_unwrap_rate_top sru_checker u_chk (.*);

`default_nettype wire

[tb/tb_scaler_record_unwrap_rate_top.sv]
// ----------------------------------------------------------------------------
// tb_scaler_record_unwrap_rate_top
// self-checking bench for the scaler record unwrap and rate block: a directed
// list of short records, then random records (good, skipped, wrong type, cut
// short, oversized, noise) under five rate scales, each output word compared
// field by field with a cycle-free model of the record parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scaler_record_unwrap_rate_top;
	import sru_pkg::*;

	localparam int          STALE_LIMIT = 4000;
	localparam int          DRAIN       = 120;
	localparam int          PHASE_WORDS = 80;
	localparam logic [47:0] EXT_TOP     = 48'((64'd1 << DEF_EXTENDED_BITS) - 64'd1);
	localparam logic [31:0] CHAN_LIMIT  = DEF_MAX_CHANNELS;

	typedef struct packed {
		in_item_t  item;
		logic      pinned;
		out_item_t result;
	} row_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_wen;
	logic [31:0] cfg_wdata;

	// model state of the record parser
	logic [31:0] tps         = TPS_RESET;
	logic [31:0] wpos        = '0;
	logic        rec_ok      = 1'b0;
	logic [31:0] chan_total  = '0;
	logic [63:0] ts_pending  = '0;
	logic [63:0] ts_now      = '0;
	logic [63:0] ts_last     = '0;
	logic [47:0] hist [DEF_MAX_CHANNELS];
	logic [31:0] hist_len    = '0;
	logic [31:0] hist_prior  = '0;

	out_item_t awaited[$];
	row_t      plan[$];

	int  errors       = 0;
	int  words_sent   = 0;
	int  results_seen = 0;
	int  recs_taken   = 0;
	int  widened      = 0;
	int  sat_rates    = 0;
	int  stale        = 0;
	bit  quiet        = 1'b0;
	bit  held         = 1'b0;

	scaler_record_unwrap_rate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [47:0] widen_count(logic [31:0] raw, logic [47:0] prev);
		logic [63:0] diff;
		logic [63:0] k;
		logic [63:0] room;
		if ({16'd0, raw} >= prev) return {16'd0, raw};
		diff = {16'd0, prev} - {32'd0, raw};
		k = diff >> DEF_WRAP_BITS;
		if (diff[DEF_WRAP_BITS-1:0] != '0) k = k + 64'd1;
		room = {16'd0, EXT_TOP} - {32'd0, raw};
		if (k > (room >> DEF_WRAP_BITS)) return EXT_TOP;
		return 48'({16'd0, raw} + (k << DEF_WRAP_BITS));
	endfunction

	function automatic logic [RATE_W-1:0] counts_per_second(logic [63:0] delta,
			logic [31:0] scale, logic [63:0] dt);
		logic [127:0] prod;
		logic [127:0] q;
		prod = {64'd0, delta} * {96'd0, scale};
		q = prod / {64'd0, dt};
		if (q > {88'd0, RATE_MAX}) return RATE_MAX;
		return q[RATE_W-1:0];
	endfunction

	// advance the parser by one accepted word
	task automatic unwrap_word(input in_item_t it, output bit got, output out_item_t r);
		logic [31:0] pos;
		logic [31:0] ch;
		logic [31:0] kept;
		logic [47:0] prev;
		logic [47:0] ext;
		logic [RATE_W-1:0] rt;
		bit has_hist;
		got = 1'b0;
		r = '0;
		if (it.record_start) begin
			ts_pending = it.timestamp;
			rec_ok = 1'b0;
			wpos = '0;
		end
		pos = wpos;
		if (wpos != '1) wpos = wpos + 32'd1;
		if (pos == 32'd1) begin
			if (it.word == SCALER_TYPE) begin
				ts_last = ts_now;
				ts_now = ts_pending;
				if (ts_now != ts_last) begin
					rec_ok = 1'b1;
					hist_prior = hist_len;
					hist_len = '0;
					chan_total = '0;
					recs_taken++;
				end
			end
			return;
		end
		if (!rec_ok || pos < COUNT_WORD) return;
		if (pos == COUNT_WORD) begin
			chan_total = it.word;
			return;
		end
		ch = pos - FIRST_COUNTER_WORD;
		kept = (chan_total < CHAN_LIMIT) ? chan_total : CHAN_LIMIT;
		if (ch >= kept) return;
		has_hist = (ch < hist_prior);
		rt = '0;
		if (has_hist) begin
			prev = hist[ch[5:0]];
			ext = widen_count(it.word, prev);
			if (ext != {16'd0, it.word}) widened++;
			if (ext != prev) rt = counts_per_second({16'd0, ext - prev}, tps, ts_now - ts_last);
			if (rt == RATE_MAX) sat_rates++;
		end else begin
			ext = {16'd0, it.word};
		end
		hist[ch[5:0]] = ext;
		hist_len = ch + 32'd1;
		r.channel = ch[5:0];
		r.extended_count = ext;
		r.rate = rt;
		r.rate_valid = has_hist;
		r.last_of_record = (ch + 32'd1 == kept);
		got = 1'b1;
	endtask

	// mostly short gaps, a few long ones, none while quiet
	function automatic int idle_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic row_t mk_row(logic [31:0] w, logic s, logic [63:0] ts, logic pin,
			out_item_t res);
		row_t rw;
		rw.item.word = w;
		rw.item.record_start = s;
		rw.item.timestamp = ts;
		rw.pinned = pin;
		rw.result = res;
		return rw;
	endfunction

	task automatic add_row(input row_t rw);
		plan = {plan, rw};
	endtask

	task automatic put_word(input row_t rw);
		int gap;
		bit got;
		out_item_t res;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= rw.item;
		do @(posedge clk); while (in_stall !== 1'b0);
		unwrap_word(rw.item, got, res);
		if (rw.pinned) begin
			awaited = {awaited, rw.result};
		end else if (got) begin
			awaited = {awaited, res};
		end
		words_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic set_tps(input logic [31:0] v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		tps = v;
	endtask

	task automatic send_record();
		int kind;
		int r;
		int n;
		logic [63:0] ts;
		logic [31:0] count;
		logic [31:0] raw;
		logic [31:0] base;
		kind = $urandom_range(0, 99);
		if (kind < 12) begin
			// loose words, mostly without a record start
			n = $urandom_range(1, 6);
			repeat (n) put_word(mk_row($urandom, $urandom_range(0, 3) == 0,
				{$urandom, $urandom}, 1'b0, '0));
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 8) ts = ts_now;
		else if (r < 16) ts = {$urandom, $urandom};
		else if (r < 24) ts = ts_now - $urandom_range(1, 5000);
		else if (r < 32) ts = ts_now + 64'd1;
		else ts = ts_now + $urandom_range(2, 200000);
		put_word(mk_row($urandom_range(9, 80), 1'b1, ts, 1'b0, '0));
		if (kind < 20) begin
			// wrong record type, near miss or anything
			raw = $urandom_range(0, 1) ? $urandom : SCALER_TYPE ^ (32'd1 << $urandom_range(0, 31));
			if (raw == SCALER_TYPE) raw = ~raw;
			put_word(mk_row(raw, 1'b0, {$urandom, $urandom}, 1'b0, '0));
			n = $urandom_range(0, 12);
			repeat (n) put_word(mk_row($urandom, 1'b0, {$urandom, $urandom}, 1'b0, '0));
			return;
		end
		put_word(mk_row(SCALER_TYPE, 1'b0, {$urandom, $urandom}, 1'b0, '0));
		repeat (6) put_word(mk_row($urandom, 1'b0, {$urandom, $urandom}, 1'b0, '0));
		r = $urandom_range(0, 99);
		if (r < 6) count = '0;
		else if (r < 14) count = 32'd64 + $urandom_range(0, 3);
		else if (r < 17) count = $urandom | 32'h80;
		else count = $urandom_range(1, 6);
		put_word(mk_row(count, 1'b0, {$urandom, $urandom}, 1'b0, '0));
		n = (count > 32'd67) ? 64 + $urandom_range(0, 3) : int'(count);
		r = $urandom_range(0, 99);
		if (r < 10 && n > 0) n = $urandom_range(0, n - 1);
		else if (r < 20) n = n + $urandom_range(1, 3);
		for (int ch = 0; ch < n; ch++) begin
			base = (ch < DEF_MAX_CHANNELS) ? hist[ch[5:0]][31:0] : $urandom;
			r = $urandom_range(0, 99);
			if (r < 12) raw = base;
			else if (r < 55) raw = base + $urandom_range(1, 1000);
			else if (r < 68) raw = base - $urandom_range(1, 1 << DEF_WRAP_BITS);
			else if (r < 76) raw = base + $urandom_range(1 << 20, 32'h7FFF_FFFF);
			else raw = $urandom;
			put_word(mk_row(raw, 1'b0, {$urandom, $urandom}, 1'b0, '0));
		end
	endtask

	// receiver: random stalls, and one long hold-off once traffic is flowing
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!held && results_seen >= 20) begin
				held = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = idle_len();
				out_stall <= (stall_left > 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	always @(posedge clk) begin : check_out
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, channel %0d count %0h", $time,
					out_data.channel, out_data.extended_count);
			end else begin
				want = awaited.pop_front();
				if (out_data.channel !== want.channel) begin
					errors++;
					$display("%0t: channel expected %0d got %0d", $time,
						want.channel, out_data.channel);
				end
				if (out_data.extended_count !== want.extended_count) begin
					errors++;
					$display("%0t: ch %0d extended_count expected %0h got %0h", $time,
						want.channel, want.extended_count, out_data.extended_count);
				end
				if (out_data.rate !== want.rate) begin
					errors++;
					$display("%0t: ch %0d rate expected %0d got %0d", $time,
						want.channel, want.rate, out_data.rate);
				end
				if (out_data.rate_valid !== want.rate_valid) begin
					errors++;
					$display("%0t: ch %0d rate_valid expected %0b got %0b", $time,
						want.channel, want.rate_valid, out_data.rate_valid);
				end
				if (out_data.last_of_record !== want.last_of_record) begin
					errors++;
					$display("%0t: ch %0d last_of_record expected %0b got %0b", $time,
						want.channel, want.last_of_record, out_data.last_of_record);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
			stale = 0;
		end else begin
			stale++;
		end
		if (stale >= STALE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stale);
			$display("tb_scaler_record_unwrap_rate_top: FAIL");
			$finish;
		end
	end

	initial begin
		logic [31:0] v;
		int target;
		foreach (hist[i]) hist[i] = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;

		// words before any record start: an implicit record at time 0, skipped
		add_row(mk_row(32'hFFFF_FFFF, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(SCALER_TYPE, 1'b0, '1, 1'b0, '0));
		// first real record, two channels with no history
		add_row(mk_row(32'd20, 1'b1, 64'd1000, 1'b0, '0));
		add_row(mk_row(SCALER_TYPE, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'd0, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'hFFFF_FFFF, 1'b0, '1, 1'b0, '0));
		add_row(mk_row(32'h8000_0000, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'h0000_0001, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'h5555_5555, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'hAAAA_AAAA, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'd2, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'hFFFF_FFFF, 1'b0, 64'd0, 1'b1,
			{6'd0, 48'h0000_FFFF_FFFF, 40'd0, 1'b0, 1'b0}));
		add_row(mk_row(32'd0, 1'b0, 64'd0, 1'b1,
			{6'd1, 48'd0, 40'd0, 1'b0, 1'b1}));
		// one tick later: channel 0 wraps past the top, channel 1 jumps to max
		add_row(mk_row(32'd11, 1'b1, 64'd1001, 1'b0, '0));
		add_row(mk_row(SCALER_TYPE, 1'b0, 64'd0, 1'b0, '0));
		repeat (6) add_row(mk_row(32'd0, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'd2, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'd5, 1'b0, 64'd0, 1'b0, '0));
		add_row(mk_row(32'hFFFF_FFFF, 1'b0, 64'd0, 1'b1,
			{6'd1, 48'h0000_FFFF_FFFF, RATE_MAX, 1'b1, 1'b1}));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_tps(TPS_RESET);
		foreach (plan[i]) put_word(plan[i]);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: v = 32'd1;
				1: v = '1;
				2: v = 32'd0;
				3: v = $urandom;
				default: v = TPS_RESET;
			endcase
			quiet = (ph == 2);
			set_tps(v);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) send_record();
			settle();
		end

		$display("covered %0d words, %0d accepted records, %0d results checked", words_sent,
			recs_taken, results_seen);
		$display("  %0d counts widened, %0d saturated rates, five rate scales incl. 0 and max",
			widened, sat_rates);
		if (errors == 0) begin
			$display("tb_scaler_record_unwrap_rate_top: PASS");
		end else begin
			$display("tb_scaler_record_unwrap_rate_top: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/sru_pkg.sv
rtl/sru_ram.sv
rtl/sru_rate_div.sv
rtl/scaler_record_unwrap_rate_top.sv
rtl/sru_checker.sv
tb/tb_scaler_record_unwrap_rate_top.sv
